[rtl/glcu_pkg.sv]
`timescale 1ns / 1ps
// Shared types, register map and helpers for the genetic life cell update block.
// No dependencies; imported by every module of the block.
package glcu_pkg;

    localparam int GENE_W   = 64;
    localparam int NBR_N    = 8;
    localparam int LANE_N   = 4;      // three candidate lanes plus the xor lane
    localparam int LANE_XOR = 3;
    localparam int IN_W     = 592;    // 585 payload bits padded to whole bytes
    localparam int OUT_W    = 72;     // 65 payload bits padded to whole bytes
    localparam int ADDR_W   = 6;
    localparam int DATA_W   = 64;

    // xorshift128+ shift amounts
    localparam int RNG_SH_A = 23;
    localparam int RNG_SH_B = 17;
    localparam int RNG_SH_C = 26;

    // adjustment threshold and offset for selection modes 1, 2 and 3, and the exponent cap
    localparam logic [6:0] ADJ_THRESH = 7'd16;
    localparam logic signed [8:0] ADJ_OFFSET = 9'sd23;
    localparam logic signed [8:0] EXP_MAX = 9'sd64;

    localparam int MUT_BASE = 24;     // mutation test starts at this random bit
    localparam int MUT_SPAN = 40;     // random bits available above MUT_BASE

    typedef enum logic [1:0] {
        MODE_NEUTRAL   = 2'd0,
        MODE_ONES      = 2'd1,
        MODE_REPLICASE = 2'd2
    } t_mode;

    typedef enum logic [2:0] {
        REG_BASE_EXP  = 3'd0,
        REG_MUT_EXP   = 3'd1,
        REG_SEL_MODE  = 3'd2,
        REG_TWO_BIRTH = 3'd3,
        REG_SEED_A    = 3'd4,
        REG_SEED_B    = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [5:0] base_exp;
        logic [4:0] mut_exp;
        logic [1:0] sel_mode;
        logic       two_birth;
    } t_cfg;

    // result of the front end for one transaction
    typedef struct packed {
        logic              active;    // two or three live neighbours
        logic              s_odd;     // odd live-neighbour count; three when active
        logic [1:0]        slot;
        logic [1:0]        n_bias;
        logic [GENE_W-1:0] rnd;
        logic [GENE_W-1:0] n_rng_a;
        logic [GENE_W-1:0] n_rng_b;
        logic [GENE_W-1:0] ga;
        logic [GENE_W-1:0] gb;
        logic [GENE_W-1:0] gc;
        logic [GENE_W-1:0] newgene;
    } t_front;

    // payload carried down the pipeline
    typedef struct packed {
        logic              center;
        logic [GENE_W-1:0] cgene;
        logic              active;
        logic              s_odd;
        logic [1:0]        slot;
        logic [GENE_W-1:0] rnd;
        logic [GENE_W-1:0] ga;
        logic [GENE_W-1:0] gb;
        logic [GENE_W-1:0] gc;
        logic [GENE_W-1:0] newgene;
    } t_pipe;

    typedef struct packed {
        logic [6:0] ones;
        logic [5:0] low3;
    } t_lane_res;

    function automatic logic signed [8:0] adjust(input logic [6:0] c);
        logic signed [8:0] v;
        v = $signed({2'b00, c});
        if (c < ADJ_THRESH) begin
            return 9'sd0;
        end
        return v - ADJ_OFFSET;
    endfunction

endpackage

[rtl/glcu_lane.sv]
`timescale 1ns / 1ps
// One counting lane: ones count and sum of the low 3 bits of each byte of a gene.
// Depends on glcu_pkg.
module glcu_lane (
    input  logic [glcu_pkg::GENE_W-1:0] i_word,
    output glcu_pkg::t_lane_res          o_res
);
    import glcu_pkg::*;

    logic [6:0] ones_sum;
    logic [5:0] low3_sum;
    logic [3:0] byte_ones [8];

    always_comb begin
        ones_sum = '0;
        low3_sum = '0;
        for (int b = 0; b < 8; b++) begin
            byte_ones[b] = 4'($countones(i_word[8*b +: 8]));
            ones_sum     = ones_sum + {3'b000, byte_ones[b]};
            low3_sum     = low3_sum + {3'b000, i_word[8*b +: 3]};
        end
        o_res.ones = ones_sum;
        o_res.low3 = low3_sum;
    end

endmodule

[rtl/glcu_front.sv]
`timescale 1ns / 1ps
// Front end: live-neighbour candidates, xorshift128+ draw, bias counter and parent pick.
// Depends on glcu_pkg.
module glcu_front (
    input  logic [7:0]                  i_alive,
    input  logic [glcu_pkg::GENE_W-1:0] i_genes [glcu_pkg::NBR_N],
    input  logic [glcu_pkg::GENE_W-1:0] i_rng_a,
    input  logic [glcu_pkg::GENE_W-1:0] i_rng_b,
    input  logic [1:0]                  i_bias,
    output glcu_pkg::t_front            o_front
);
    import glcu_pkg::*;

    logic [3:0]        cnt;
    logic [2:0]        cand [3];
    logic [GENE_W-1:0] x;
    logic [GENE_W-1:0] nb;
    logic [1:0]        q;
    logic [1:0]        nbias;
    logic [1:0]        slot;
    logic [GENE_W-1:0] rnd;

    // highest live index first; unused slots stay at east
    always_comb begin
        cnt = '0;
        for (int i = 0; i < 3; i++) cand[i] = '0;
        for (int k = NBR_N - 1; k >= 0; k--) begin
            if (i_alive[k]) begin
                if (cnt == 4'd0) cand[0] = 3'(k);
                else if (cnt == 4'd1) cand[1] = 3'(k);
                else if (cnt == 4'd2) cand[2] = 3'(k);
                cnt = cnt + 4'd1;
            end
        end
    end

    always_comb begin
        x     = i_rng_a ^ (i_rng_a << RNG_SH_A);
        nb    = x ^ i_rng_b ^ (x >> RNG_SH_B) ^ (i_rng_b >> RNG_SH_C);
        rnd   = nb + i_rng_b;
        q     = rnd[55:54];
        nbias = i_bias;
        if (q == 2'd3) begin
            nbias = (i_bias == 2'd2) ? 2'd0 : i_bias + 2'd1;
        end
        if (cnt[0]) slot = (q == 2'd3) ? nbias : q;
        else        slot = {1'b0, q[0]};
        if (slot == 2'd3) slot = 2'd0;
    end

    always_comb begin
        o_front.active  = (cnt == 4'd2) || (cnt == 4'd3);
        o_front.s_odd   = cnt[0];
        o_front.slot    = slot;
        o_front.n_bias  = nbias;
        o_front.rnd     = rnd;
        o_front.n_rng_a = i_rng_b;
        o_front.n_rng_b = nb;
        o_front.ga      = i_genes[cand[0]];
        o_front.gb      = i_genes[cand[1]];
        o_front.gc      = i_genes[cand[2]];
        o_front.newgene = i_genes[cand[slot]];
    end

endmodule

[rtl/glcu_merge.sv]
`timescale 1ns / 1ps
// Merge stage: combines lane counts into the departure exponent, draws departure,
// mutation and birth, and forms the next cell state. Depends on glcu_pkg.
module glcu_merge (
    input  glcu_pkg::t_cfg              i_cfg,
    input  glcu_pkg::t_pipe             i_pipe,
    input  glcu_pkg::t_lane_res         i_lane [glcu_pkg::LANE_N],
    output logic                        o_next_alive,
    output logic [glcu_pkg::GENE_W-1:0] o_next_gene
);
    import glcu_pkg::*;

    logic [5:0]        low3_min;
    logic signed [8:0] adj;
    logic signed [8:0] e_raw;
    logic [6:0]        e_sat;
    logic              depart;
    logic              mutate;
    logic [GENE_W-1:0] gene_m;
    logic              birth;

    always_comb begin
        low3_min = i_lane[0].low3;
        if (i_lane[1].low3 < low3_min) low3_min = i_lane[1].low3;
        if (i_lane[2].low3 < low3_min) low3_min = i_lane[2].low3;

        case (i_cfg.sel_mode)
            MODE_NEUTRAL: adj = $signed({2'b00, i_lane[LANE_XOR].ones});
            MODE_ONES:    adj = adjust(i_lane[i_pipe.slot].ones);
            default:      adj = adjust({1'b0, low3_min});
        endcase

        e_raw = $signed({3'b000, i_cfg.base_exp}) + adj;
        if (e_raw < 9'sd0)        e_sat = '0;
        else if (e_raw > EXP_MAX) e_sat = 7'(EXP_MAX);
        else                      e_sat = e_raw[6:0];

        depart = 1'b1;
        for (int j = 0; j < GENE_W; j++) begin
            if ((7'(j) < e_sat) && i_pipe.rnd[j]) depart = 1'b0;
        end

        mutate = 1'b1;
        for (int j = 0; j < MUT_SPAN; j++) begin
            if ((6'(j) < {1'b0, i_cfg.mut_exp}) && i_pipe.rnd[MUT_BASE + j]) mutate = 1'b0;
        end

        gene_m = i_pipe.newgene;
        if (mutate) gene_m = gene_m ^ (64'd1 << i_pipe.rnd[53:48]);

        birth = !i_pipe.center && (i_pipe.s_odd ^ (depart && i_cfg.two_birth));

        if (!i_pipe.active) begin
            o_next_alive = 1'b0;
            o_next_gene  = '0;
        end else begin
            o_next_alive = i_pipe.center || birth;
            o_next_gene  = i_pipe.center ? i_pipe.cgene : (birth ? gene_m : '0);
        end
    end

endmodule

[rtl/genetic_life_cell_update_core.sv]
`timescale 1ns / 1ps
// Pipeline: three register stages, stage 1 (candidate genes), stage 2 (lane counts)
// and the output register, which drives a result's tvalid.
// Throughput: one transaction per cycle while the output is not stalled; the generator
// and bias counter step in the accept cycle, so that update loop sets the rate.
// Reset (synchronous, active low): pipeline empty, registers 5/5/1/1, seeds 1 and 2,
// generator words 1 and 2, bias counter 0. No clearing pass.
// Depends on glcu_pkg, glcu_front, glcu_lane, glcu_merge.
module genetic_life_cell_update_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream; tdata from bit 0: center_alive, neighbour_alive[7:0], center_gene,
    // gene_east, gene_west, gene_south, gene_southeast, gene_southwest, gene_north,
    // gene_northeast, gene_northwest, zero pad
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [glcu_pkg::IN_W-1:0]     i_s_axis_tdata,
    // master stream; tdata from bit 0: next_alive, next_gene[63:0], zero pad
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [glcu_pkg::OUT_W-1:0]    o_m_axis_tdata,
    // APB configuration port
    input  logic                          i_psel,
    input  logic                          i_penable,
    input  logic                          i_pwrite,
    input  logic [glcu_pkg::ADDR_W-1:0]   i_paddr,
    input  logic [glcu_pkg::DATA_W-1:0]   i_pwdata,
    output logic [glcu_pkg::DATA_W-1:0]   o_prdata,
    output logic                          o_pready
);
    import glcu_pkg::*;

    // ---------------- configuration ----------------
    t_cfg              r_cfg;
    logic [GENE_W-1:0] r_seed_a;
    logic [GENE_W-1:0] r_seed_b;
    logic              cfg_wr;
    t_reg_idx          cfg_idx;

    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite && o_pready;
    assign cfg_idx  = t_reg_idx'(i_paddr[5:3]);   // registers on 8-byte spacing

    always_comb begin
        unique case (cfg_idx)
            REG_BASE_EXP:  o_prdata = {58'd0, r_cfg.base_exp};
            REG_MUT_EXP:   o_prdata = {59'd0, r_cfg.mut_exp};
            REG_SEL_MODE:  o_prdata = {62'd0, r_cfg.sel_mode};
            REG_TWO_BIRTH: o_prdata = {63'd0, r_cfg.two_birth};
            REG_SEED_A:    o_prdata = r_seed_a;
            REG_SEED_B:    o_prdata = r_seed_b;
            default:       o_prdata = '0;
        endcase
    end

    // ---------------- input unpack ----------------
    logic              in_center;
    logic [7:0]        in_alive;
    logic [GENE_W-1:0] in_cgene;
    logic [GENE_W-1:0] in_genes [NBR_N];

    always_comb begin
        in_center = i_s_axis_tdata[0];
        in_alive  = i_s_axis_tdata[8:1];
        in_cgene  = i_s_axis_tdata[72:9];
        for (int k = 0; k < NBR_N; k++) begin
            in_genes[k] = i_s_axis_tdata[73 + GENE_W*k +: GENE_W];
        end
    end

    // ---------------- handshake / pipeline flow ----------------
    // Each stage moves when it is empty or its successor moves, so bubbles are
    // squeezed out and the input keeps flowing while a result waits and a stage is empty.
    logic r_v1, r_v2, r_out_valid;
    logic rdy_out, rdy2, rdy1;
    logic s_acc;

    assign rdy_out         = !r_out_valid || i_m_axis_tready;
    assign rdy2            = !r_v2 || rdy_out;
    assign rdy1            = !r_v1 || rdy2;
    assign o_s_axis_tready = rdy1;
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;

    // ---------------- front end (accept cycle) ----------------
    logic [GENE_W-1:0] r_rng_a;
    logic [GENE_W-1:0] r_rng_b;
    logic [1:0]        r_bias;
    t_front            front;

    glcu_front u_front (
        .i_alive           (in_alive),
        .i_genes           (in_genes),
        .i_rng_a           (r_rng_a),
        .i_rng_b           (r_rng_b),
        .i_bias            (r_bias),
        .o_front           (front)
    );

    // generator state, bias counter and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.base_exp  <= 6'd5;
            r_cfg.mut_exp   <= 5'd5;
            r_cfg.sel_mode  <= MODE_ONES;
            r_cfg.two_birth <= 1'b1;
            r_seed_a        <= 64'd1;
            r_seed_b        <= 64'd2;
            r_rng_a         <= 64'd1;
            r_rng_b         <= 64'd2;
            r_bias          <= 2'd0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_BASE_EXP:  r_cfg.base_exp  <= i_pwdata[5:0];
                REG_MUT_EXP:   r_cfg.mut_exp   <= i_pwdata[4:0];
                REG_SEL_MODE:  r_cfg.sel_mode  <= i_pwdata[1:0];
                REG_TWO_BIRTH: r_cfg.two_birth <= i_pwdata[0];
                REG_SEED_A: begin
                    r_seed_a <= i_pwdata;
                    r_rng_a  <= i_pwdata;
                end
                REG_SEED_B: begin
                    r_seed_b <= i_pwdata;
                    r_rng_b  <= i_pwdata;
                end
                default: ;
            endcase
        end else if (s_acc && front.active) begin
            // draw only when two or three neighbours live
            r_rng_a <= front.n_rng_a;
            r_rng_b <= front.n_rng_b;
            r_bias  <= front.n_bias;
        end
    end

    // ---------------- stage 1: candidate genes registered ----------------
    t_pipe r_p1;
    t_pipe n_p1;

    always_comb begin
        n_p1.center  = in_center;
        n_p1.cgene   = in_cgene;
        n_p1.active  = front.active;
        n_p1.s_odd   = front.s_odd;
        n_p1.slot    = front.slot;
        n_p1.rnd     = front.rnd;
        n_p1.ga      = front.ga;
        n_p1.gb      = front.gb;
        n_p1.gc      = front.gc;
        n_p1.newgene = front.newgene;
    end

    // ---------------- lanes ----------------
    logic [GENE_W-1:0] lane_word [LANE_N];
    t_lane_res         lane_res  [LANE_N];

    assign lane_word[0]        = r_p1.ga;
    assign lane_word[1]        = r_p1.gb;
    assign lane_word[2]        = r_p1.gc;
    assign lane_word[LANE_XOR] = r_p1.ga ^ r_p1.gb ^ r_p1.gc;

    for (genvar l = 0; l < LANE_N; l++) begin : g_lane
        glcu_lane u_lane (
            .i_word (lane_word[l]),
            .o_res  (lane_res[l])
        );
    end

    // ---------------- stage 2: lane counts registered ----------------
    t_pipe     r_p2;
    t_lane_res r_p2_lane [LANE_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= s_acc;
            if (rdy2) r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1) r_p1 <= n_p1;
        if (rdy2) begin
            r_p2      <= r_p1;
            r_p2_lane <= lane_res;
        end
    end

    // ---------------- merge and output register ----------------
    logic              mg_alive;
    logic [GENE_W-1:0] mg_gene;
    logic [OUT_W-1:0]  r_out_data;

    glcu_merge u_merge (
        .i_cfg        (r_cfg),
        .i_pipe       (r_p2),
        .i_lane       (r_p2_lane),
        .o_next_alive (mg_alive),
        .o_next_gene  (mg_gene)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rdy_out) begin
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy_out) r_out_data <= {7'd0, mg_gene, mg_alive};
    end

    assign o_m_axis_tdata = r_out_data;

    // ---------------- assertions ----------------
    // generator and bias counter move only on a drawing transaction or a seed write
    a_rng_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!cfg_wr && !(s_acc && front.active))
        |=> ($stable(r_rng_a) && $stable(r_rng_b) && $stable(r_bias)))
        else $error("generator state changed without a draw");

    // bias counter counts mod 3
    a_bias_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bias != 2'd3))
        else $error("bias counter out of range");

    // an empty cell never carries a gene
    a_dead_gene: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_data[0]) |-> (r_out_data[64:1] == '0))
        else $error("empty cell with nonzero gene");

    // a stalled stage 2 keeps its transaction
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !rdy2) |=> (r_v2 && $stable(r_p2.rnd)))
        else $error("stage 2 transaction lost under stall");

endmodule

[bench/genetic_life_cell_update_core_tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for genetic_life_cell_update_core: random and directed cells
// are streamed in and every result is checked against an in-bench next-state model.
// Depends on glcu_pkg and the core RTL.
module genetic_life_cell_update_core_tb;
    import glcu_pkg::*;

    localparam int CLK_HALF   = 10;
    localparam int RST_CYCLES = 11;
    localparam int PIPE_LAT   = 3;
    localparam int CYCLE_MAX  = 200000;
    localparam int REPORT_MAX = 10;

    // selection mode 3 is not in t_mode; the core treats it as the replicase mode
    localparam logic [1:0] MODE_ALIAS_REPLICASE = 2'd3;

    // one input transaction: the cell and its eight neighbours
    typedef struct packed {
        logic                  center;
        logic [NBR_N-1:0]      nbr;       // bit k = neighbour k (E W S SE SW N NE NW)
        logic [GENE_W-1:0]     cgene;
        logic [NBR_N-1:0][GENE_W-1:0] gene;
    } t_cell;

    // one output transaction
    typedef struct packed {
        logic              alive;
        logic [GENE_W-1:0] gene;
    } t_next_cell;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_s_axis_tvalid = 1'b0;
    logic               o_s_axis_tready;
    // from bit 0: center_alive, neighbour_alive[7:0], center_gene, gene_east .. gene_northwest
    logic [IN_W-1:0]    i_s_axis_tdata = '0;
    logic               o_m_axis_tvalid;
    logic               i_m_axis_tready = 1'b0;
    // from bit 0: next_alive, next_gene[63:0]
    logic [OUT_W-1:0]   o_m_axis_tdata;
    logic               i_psel = 1'b0;
    logic               i_penable = 1'b0;
    logic               i_pwrite = 1'b0;
    logic [ADDR_W-1:0]  i_paddr = '0;
    logic [DATA_W-1:0]  i_pwdata = '0;
    logic [DATA_W-1:0]  o_prdata;
    logic               o_pready;

    genetic_life_cell_update_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_psel          (i_psel),
        .i_penable       (i_penable),
        .i_pwrite        (i_pwrite),
        .i_paddr         (i_paddr),
        .i_pwdata        (i_pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // model copy of the registers and of the generator / bias counter
    logic [5:0]        cfg_base  = 6'd5;
    logic [4:0]        cfg_mut   = 5'd5;
    logic [1:0]        cfg_mode  = MODE_ONES;
    logic              cfg_twob  = 1'b1;
    logic [GENE_W-1:0] gen_a     = 64'd1;
    logic [GENE_W-1:0] gen_b     = 64'd2;
    logic [1:0]        bias_cnt  = 2'd0;

    t_cell      cells_pending [$];
    t_next_cell next_cells_due [$];
    t_cell      cell_in_flight;

    int  src_idle_pct   = 0;
    int  sink_stall_pct = 0;
    logic src_hold      = 1'b0;
    int  mismatch_count = 0;
    int  cycle_count    = 0;

    // ------------------------------------------------------------------
    // next-state model
    // ------------------------------------------------------------------
    function automatic int departure_shift(input int c);
        return (c < 16) ? 0 : c - 23;
    endfunction

    // sum of the low three bits of every byte
    function automatic int byte_low3_sum(input logic [GENE_W-1:0] x);
        int acc;
        acc = 0;
        for (int b = 0; b < 8; b++) acc += int'(x[8*b +: 3]);
        return acc;
    endfunction

    task automatic predict_next_cell(input t_cell c);
        int         live_n;
        int         cand [3];
        int         slot;
        int         adj;
        int         ex;
        int         m;
        logic [GENE_W-1:0] x, y, rnd, ga, gb, gc, child, pmask, mmask;
        logic [1:0] q;
        logic       depart, mutate, birth;
        t_next_cell res;
        live_n = 0;
        cand = '{0, 0, 0};
        // candidates: live neighbours, highest index first; unused slots stay east
        for (int k = NBR_N - 1; k >= 0; k--) begin
            if (c.nbr[k]) begin
                if (live_n < 3) cand[live_n] = k;
                live_n++;
            end
        end
        if (live_n != 2 && live_n != 3) begin
            // no draw, no state change, cell empties whatever it was
            res = '0;
        end else begin
            // xorshift128+ step
            x = gen_a;
            y = gen_b;
            gen_a = y;
            x = x ^ (x << RNG_SH_A);
            gen_b = x ^ y ^ (x >> RNG_SH_B) ^ (y >> RNG_SH_C);
            rnd = gen_b + y;

            q = rnd[55:54];
            if (q == 2'd3) bias_cnt = (bias_cnt == 2'd2) ? 2'd0 : bias_cnt + 2'd1;
            if (live_n == 3) slot = (q == 2'd3) ? int'(bias_cnt) : int'(q);
            else slot = int'(q[0]);

            ga = c.gene[cand[0]];
            gb = c.gene[cand[1]];
            gc = c.gene[cand[2]];
            child = c.gene[cand[slot]];

            case (cfg_mode)
                MODE_NEUTRAL: adj = $countones(ga ^ gb ^ gc);
                MODE_ONES:    adj = departure_shift($countones(child));
                default: begin
                    m = byte_low3_sum(ga);
                    if (byte_low3_sum(gb) < m) m = byte_low3_sum(gb);
                    if (byte_low3_sum(gc) < m) m = byte_low3_sum(gc);
                    adj = departure_shift(m);
                end
            endcase

            ex = int'(cfg_base) + adj;
            if (ex < 0) ex = 0;
            if (ex > 64) ex = 64;
            pmask = (ex >= 64) ? '1 : ((64'd1 << ex) - 64'd1);
            depart = ((rnd & pmask) == '0);

            mmask = (64'd1 << cfg_mut) - 64'd1;
            mutate = (((rnd >> MUT_BASE) & mmask) == '0);
            if (mutate) child = child ^ (64'd1 << rnd[53:48]);

            birth = !c.center && ((live_n == 3) ^ (depart && cfg_twob));
            res.alive = c.center | birth;
            res.gene  = c.center ? c.cgene : (birth ? child : '0);
        end
        next_cells_due.push_back(res);
    endtask

    function automatic logic [IN_W-1:0] pack_cell(input t_cell c);
        logic [IN_W-1:0] v;
        v = '0;
        v[0]    = c.center;
        v[8:1]  = c.nbr;
        v[72:9] = c.cgene;
        for (int k = 0; k < NBR_N; k++) v[73 + GENE_W*k +: GENE_W] = c.gene[k];
        return v;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [GENE_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // genes biased so that popcounts and byte sums fall on both sides of 16
    function automatic logic [GENE_W-1:0] rand_gene();
        logic [GENE_W-1:0] g;
        g = rand_word();
        case ($urandom_range(7))
            0:       g = '0;
            1:       g = '1;
            2, 3:    g = g & rand_word() & rand_word();
            4:       g = g | rand_word();
            default: ;
        endcase
        return g;
    endfunction

    function automatic logic [NBR_N-1:0] rand_nbr();
        logic [NBR_N-1:0] n;
        int want;
        n = '0;
        if ($urandom_range(99) < 70) begin
            // the interesting case: exactly two or three live neighbours
            want = $urandom_range(3, 2);
            while ($countones(n) < want) n[$urandom_range(NBR_N - 1)] = 1'b1;
        end else begin
            n = NBR_N'($urandom_range(255));
        end
        return n;
    endfunction

    // style: 0 random genes, 1 all zero, 2 all ones
    function automatic t_cell make_cell(input logic ctr, input logic [NBR_N-1:0] n,
                                        input int style);
        t_cell c;
        c.center = ctr;
        c.nbr    = n;
        c.cgene  = (style == 1) ? '0 : (style == 2) ? '1 : rand_gene();
        for (int k = 0; k < NBR_N; k++)
            c.gene[k] = (style == 1) ? '0 : (style == 2) ? '1 : rand_gene();
        return c;
    endfunction

    // ------------------------------------------------------------------
    // source driver: pops pending cells, holds tvalid until accepted
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_next_cell(cell_in_flight);
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (cells_pending.size() > 0 && !src_hold &&
                    $urandom_range(99) >= src_idle_pct) begin
                    cell_in_flight  <= cells_pending[0];
                    i_s_axis_tdata  <= pack_cell(cells_pending[0]);
                    i_s_axis_tvalid <= 1'b1;
                    void'(cells_pending.pop_front());
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // sink monitor: random back-pressure, checks every result transaction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_next_cell exp_cell;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (next_cells_due.size() == 0) begin
                    if (mismatch_count < REPORT_MAX)
                        $display("unexpected result alive=%0b gene=%h",
                                 o_m_axis_tdata[0], o_m_axis_tdata[64:1]);
                    mismatch_count++;
                end else begin
                    exp_cell = next_cells_due.pop_front();
                    if (o_m_axis_tdata[0] !== exp_cell.alive ||
                        o_m_axis_tdata[64:1] !== exp_cell.gene) begin
                        if (mismatch_count < REPORT_MAX)
                            $display("mismatch: alive exp %0b got %0b, gene exp %h got %h",
                                     exp_cell.alive, o_m_axis_tdata[0],
                                     exp_cell.gene, o_m_axis_tdata[64:1]);
                        mismatch_count++;
                    end
                end
            end
            i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_MAX) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequencing
    // ------------------------------------------------------------------
    // wait until every predicted result has arrived; with_pending also waits
    // for the pending queue to empty
    task automatic wait_drained(input bit with_pending);
        @(posedge i_clk);
        while ((with_pending && cells_pending.size() != 0) || i_s_axis_tvalid ||
               next_cells_due.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 3) @(posedge i_clk);
    endtask

    // APB write with a setup phase and an access phase; model updated at the access edge
    task automatic write_reg(input t_reg_idx idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_psel    <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b1;
        i_paddr   <= ADDR_W'(int'(idx) * 8);
        i_pwdata  <= val;
        @(posedge i_clk);
        i_penable <= 1'b1;
        @(posedge i_clk);
        case (idx)
            REG_BASE_EXP:  cfg_base = val[5:0];
            REG_MUT_EXP:   cfg_mut  = val[4:0];
            REG_SEL_MODE:  cfg_mode = val[1:0];
            REG_TWO_BIRTH: cfg_twob = val[0];
            REG_SEED_A:    gen_a    = val;
            REG_SEED_B:    gen_b    = val;
            default: ;
        endcase
        i_psel    <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input logic [5:0] base, input logic [4:0] mexp,
                             input logic [1:0] mode, input logic twob,
                             input logic [GENE_W-1:0] seed_a,
                             input logic [GENE_W-1:0] seed_b,
                             input int n_cells, input int idle_pct, input int stall_pct,
                             input bit mid_pause);
        wait_drained(1'b1);
        write_reg(REG_BASE_EXP, DATA_W'(base));
        write_reg(REG_MUT_EXP, DATA_W'(mexp));
        write_reg(REG_SEL_MODE, DATA_W'(mode));
        write_reg(REG_TWO_BIRTH, DATA_W'(twob));
        write_reg(REG_SEED_A, seed_a);
        write_reg(REG_SEED_B, seed_b);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        for (int i = 0; i < n_cells; i++) begin
            cells_pending.push_back(make_cell(1'($urandom_range(1)), rand_nbr(), 0));
            // source holds off mid-phase until the pipeline has fully drained
            if (mid_pause && i == n_cells / 2) begin
                wait (cells_pending.size() == 0);
                src_hold <= 1'b1;
                wait_drained(1'b0);
                src_hold <= 1'b0;
            end
        end
    endtask

    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed cells under the reset configuration
        cells_pending.push_back(make_cell(1'b1, 8'h00, 2));    // no neighbours
        cells_pending.push_back(make_cell(1'b1, 8'hFF, 2));    // all eight
        cells_pending.push_back(make_cell(1'b0, 8'hFF, 1));
        cells_pending.push_back(make_cell(1'b1, 8'h01, 0));    // lone east
        cells_pending.push_back(make_cell(1'b0, 8'h03, 0));    // two, east and west
        cells_pending.push_back(make_cell(1'b1, 8'h03, 0));    // survivor on two
        cells_pending.push_back(make_cell(1'b0, 8'h07, 0));    // three lowest
        cells_pending.push_back(make_cell(1'b1, 8'h07, 2));    // survivor on three
        cells_pending.push_back(make_cell(1'b0, 8'hE0, 0));    // three highest
        cells_pending.push_back(make_cell(1'b0, 8'hC0, 0));
        cells_pending.push_back(make_cell(1'b0, 8'h81, 2));
        cells_pending.push_back(make_cell(1'b0, 8'h07, 1));    // zero genes
        cells_pending.push_back(make_cell(1'b0, 8'h07, 2));    // all-ones genes
        cells_pending.push_back(make_cell(1'b0, 8'h0F, 0));    // four
        cells_pending.push_back(make_cell(1'b1, 8'h1F, 0));
        for (int i = 0; i < 8; i++)
            cells_pending.push_back(make_cell(i[0], rand_nbr(), 0));

        // register sweeps, extremes first, with the four idle profiles
        run_phase(6'd0, 5'd0, MODE_NEUTRAL, 1'b1, rand_word(), rand_word(),
                  120, 0, 0, 1'b0);
        run_phase(6'd63, 5'd24, MODE_ONES, 1'b0, rand_word(), rand_word(),
                  120, 56, 0, 1'b0);
        run_phase(6'd3, 5'd2, MODE_REPLICASE, 1'b1, rand_word(), rand_word(),
                  120, 0, 56, 1'b0);
        run_phase(6'($urandom_range(63)), 5'($urandom_range(24)), MODE_ALIAS_REPLICASE,
                  1'($urandom_range(1)), rand_word(), rand_word(), 110, 30, 30, 1'b0);
        // both generator words zero: generator stays stuck at zero
        run_phase(6'd2, 5'd1, MODE_ONES, 1'b1, 64'd0, 64'd0, 30, 0, 0, 1'b0);
        run_phase(6'($urandom_range(63)), 5'($urandom_range(24)),
                  2'($urandom_range(2)), 1'($urandom_range(1)), '1, '1,
                  120, 30, 30, 1'b1);

        wait_drained(1'b1);
        if (next_cells_due.size() != 0) mismatch_count++;
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
